// File: hdl/mpd_pkg.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// mpd_pkg
// Shared types and constants for the mouse packet event decoder.
// -----------------------------------------------------------------------------
package mpd_pkg;

   // header bit masks
   localparam logic [7:0] HDR_SYNC     = 8'h08;
   localparam logic [7:0] HDR_OVERFLOW = 8'hC0;
   localparam int         HDR_XSIGN_BIT = 4;
   localparam int         HDR_YSIGN_BIT = 5;

   // event kinds
   localparam logic KIND_BUTTON = 1'b0;
   localparam logic KIND_MOTION = 1'b1;

   // event codes
   localparam logic [1:0] CODE_LEFT   = 2'd0;
   localparam logic [1:0] CODE_RIGHT  = 2'd1;
   localparam logic [1:0] CODE_MIDDLE = 2'd2;
   localparam logic [1:0] CODE_X      = 2'd0;
   localparam logic [1:0] CODE_Y      = 2'd1;

   // slots of the pending-event mask, in emission order
   localparam int SLOT_LEFT   = 0;
   localparam int SLOT_RIGHT  = 1;
   localparam int SLOT_MIDDLE = 2;
   localparam int SLOT_X      = 3;
   localparam int SLOT_Y      = 4;
   localparam int NUM_SLOTS   = 5;

   // one decoded packet waiting for the back end
   typedef struct packed {
      logic [NUM_SLOTS-1:0] mask;     // events to emit
      logic [2:0]           buttons;  // new button state
      logic signed [9:0]    dx;
      logic signed [9:0]    dy;
   } mpd_entry_type;

   // one result event
   typedef struct packed {
      logic              kind;
      logic [1:0]        code;
      logic signed [9:0] value;
      logic              last;
   } mpd_event_type;

endpackage

// File: hdl/mpd_front.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// mpd_front
// Byte framer: syncs on the header, collects three bytes and classifies the
// packet into a set of pending events for the queue.
// -----------------------------------------------------------------------------
module mpd_front
   import mpd_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          byte_valid,
   output logic          byte_ready,
   input  logic [7:0]    rx_byte,
   input  logic          from_aux,
   input  logic          csr_valid,
   input  logic          csr_data,
   output logic          push,
   output mpd_entry_type push_entry,
   input  logic          queue_full
);

   logic [1:0] pos_ff, pos_in;
   logic [7:0] header_ff, header_in;
   logic [7:0] x_ff, x_in;
   logic [2:0] buttons_ff, buttons_in;
   logic       enable_ff, enable_in;

   logic       accept;
   logic       third;
   logic [2:0] changed;
   logic signed [9:0] dx;
   logic signed [9:0] y_raw;
   logic signed [9:0] dy;
   logic       emit;

   assign byte_ready = !queue_full;
   assign accept     = byte_valid && byte_ready && from_aux;
   assign third      = accept && (pos_ff[1] == 1'b1);

   // packet classification from stored header, X byte and current Y byte
   assign changed = header_ff[2:0] ^ buttons_ff;
   assign dx      = {header_ff[HDR_XSIGN_BIT], header_ff[HDR_XSIGN_BIT], x_ff};
   assign y_raw   = {header_ff[HDR_YSIGN_BIT], header_ff[HDR_YSIGN_BIT], rx_byte};
   assign dy      = -y_raw;
   assign emit    = third && ((header_ff & HDR_OVERFLOW) == 8'h00) && enable_ff;

   always_comb begin
      push_entry.mask[SLOT_MIDDLE:SLOT_LEFT] = changed;
      push_entry.mask[SLOT_X] = (dx != 10'sd0);
      push_entry.mask[SLOT_Y] = (dy != 10'sd0);
      push_entry.buttons = header_ff[2:0];
      push_entry.dx      = dx;
      push_entry.dy      = dy;
   end

   assign push = emit && (push_entry.mask != '0);

   // framing state
   always_comb begin
      pos_in     = pos_ff;
      header_in  = header_ff;
      x_in       = x_ff;
      buttons_in = buttons_ff;
      enable_in  = csr_valid ? csr_data : enable_ff;
      if (accept) begin
         unique case (pos_ff)
            2'd0: begin
               if ((rx_byte & HDR_SYNC) != 8'h00) begin
                  header_in = rx_byte;
                  pos_in    = 2'd1;
               end
            end
            2'd1: begin
               x_in   = rx_byte;
               pos_in = 2'd2;
            end
            default: begin
               pos_in = 2'd0;
               if (emit) buttons_in = header_ff[2:0];
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= 2'd0;
         header_ff  <= 8'h00;
         x_ff       <= 8'h00;
         buttons_ff <= 3'b000;
         enable_ff  <= 1'b1;
      end else begin
         pos_ff     <= pos_in;
         header_ff  <= header_in;
         x_ff       <= x_in;
         buttons_ff <= buttons_in;
         enable_ff  <= enable_in;
      end
   end

endmodule

// File: hdl/mpd_queue.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// mpd_queue
// Short FIFO of decoded packets between front and back end.
// -----------------------------------------------------------------------------
module mpd_queue
   import mpd_pkg::*;
#(
   parameter int DEPTH = 2
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  mpd_entry_type push_entry,
   output logic          full,
   input  logic          pop,
   output logic          not_empty,
   output mpd_entry_type pop_entry
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

   mpd_entry_type store_ff [DEPTH];
   logic [PW-1:0] wr_ff, wr_in;
   logic [PW-1:0] rd_ff, rd_in;
   logic [CW-1:0] cnt_ff, cnt_in;

   assign full      = (cnt_ff == FULL_CNT);
   assign not_empty = (cnt_ff != '0);
   assign pop_entry = store_ff[rd_ff];

   // pointer and count update
   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) wr_in = (wr_ff == LAST_PTR) ? '0 : wr_ff + PW'(1);
      if (pop)  rd_in = (rd_ff == LAST_PTR) ? '0 : rd_ff + PW'(1);
      if (push && !pop) cnt_in = cnt_ff + CW'(1);
      else if (pop && !push) cnt_in = cnt_ff - CW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) store_ff[wr_ff] <= push_entry;
   end

endmodule

// File: hdl/mpd_back.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// mpd_back
// Event sequencer: walks the pending mask of one packet, one event per beat,
// into a registered output stage.
// -----------------------------------------------------------------------------
module mpd_back
   import mpd_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          queue_not_empty,
   input  mpd_entry_type queue_entry,
   output logic          pop,
   output logic          out_valid,
   input  logic          out_ready,
   output mpd_event_type out_event
);

   mpd_entry_type         cur_ff, cur_in;
   logic [NUM_SLOTS-1:0]  pend_ff, pend_in;
   logic                  valid_ff, valid_in;
   mpd_event_type         event_ff, event_in;

   logic                  advance;
   logic [NUM_SLOTS-1:0]  sel;
   logic [NUM_SLOTS-1:0]  rest;
   mpd_event_type         next_event;

   assign advance = !valid_ff || out_ready;

   // lowest pending slot goes first
   always_comb begin
      sel = '0;
      priority if (pend_ff[SLOT_LEFT])   sel[SLOT_LEFT]   = 1'b1;
      else if     (pend_ff[SLOT_RIGHT])  sel[SLOT_RIGHT]  = 1'b1;
      else if     (pend_ff[SLOT_MIDDLE]) sel[SLOT_MIDDLE] = 1'b1;
      else if     (pend_ff[SLOT_X])      sel[SLOT_X]      = 1'b1;
      else if     (pend_ff[SLOT_Y])      sel[SLOT_Y]      = 1'b1;
      else                               sel = '0;
   end

   assign rest = pend_ff & ~sel;

   // build the selected event
   always_comb begin
      next_event.kind  = KIND_BUTTON;
      next_event.code  = CODE_LEFT;
      next_event.value = {9'd0, cur_ff.buttons[SLOT_LEFT]};
      next_event.last  = (rest == '0);
      if (sel[SLOT_RIGHT]) begin
         next_event.code  = CODE_RIGHT;
         next_event.value = {9'd0, cur_ff.buttons[SLOT_RIGHT]};
      end else if (sel[SLOT_MIDDLE]) begin
         next_event.code  = CODE_MIDDLE;
         next_event.value = {9'd0, cur_ff.buttons[SLOT_MIDDLE]};
      end else if (sel[SLOT_X]) begin
         next_event.kind  = KIND_MOTION;
         next_event.code  = CODE_X;
         next_event.value = cur_ff.dx;
      end else if (sel[SLOT_Y]) begin
         next_event.kind  = KIND_MOTION;
         next_event.code  = CODE_Y;
         next_event.value = cur_ff.dy;
      end
   end

   // sequencing and output stage
   always_comb begin
      cur_in   = cur_ff;
      pend_in  = pend_ff;
      valid_in = valid_ff;
      event_in = event_ff;
      pop      = 1'b0;
      if (advance) begin
         valid_in = (pend_ff != '0);
         if (pend_ff != '0) event_in = next_event;
         pend_in = rest;
      end
      // refill once the current packet has nothing more to give
      if (pend_in == '0 && queue_not_empty) begin
         pop     = 1'b1;
         cur_in  = queue_entry;
         pend_in = queue_entry.mask;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         pend_ff  <= pend_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff   <= cur_in;
      event_ff <= event_in;
   end

   assign out_valid = valid_ff;
   assign out_event = event_ff;

endmodule

// File: hdl/mouse_packet_event_decoder.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// mouse_packet_event_decoder
// Three-byte mouse packet decoder producing button and motion events.
// -----------------------------------------------------------------------------
// The block takes one received byte per beat and turns every complete,
// overflow-free three-byte mouse packet into up to five events: one per
// changed button (left, right, middle), then X motion, then negated Y motion,
// the last one flagged on rsp_tlast. A byte is taken in every cycle while the
// packet queue has room; the event sequencer delivers one event per cycle
// while rsp_tready is high, and the queue depth (QUEUE_DEPTH packets) sets
// how far the front end may run ahead of it.
// Writes on the csr channel are always accepted and set the events enable.
module mouse_packet_event_decoder
   import mpd_pkg::*;
#(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   // received bytes
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   input  logic        req_tuser,   // [0] from_aux
   // events
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [1:0] event_code, [11:2] event_value, rest zero
   output logic        rsp_tuser,   // [0] event_kind
   output logic        rsp_tlast,   // last_event
   // configuration
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_data     // events_enable
);

   logic          push;
   mpd_entry_type push_entry;
   logic          queue_full;
   logic          pop;
   logic          queue_not_empty;
   mpd_entry_type pop_entry;
   mpd_event_type out_event;

   assign csr_ready = 1'b1;

   mpd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .byte_valid (req_tvalid),
      .byte_ready (req_tready),
      .rx_byte    (req_tdata),
      .from_aux   (req_tuser),
      .csr_valid  (csr_valid),
      .csr_data   (csr_data),
      .push       (push),
      .push_entry (push_entry),
      .queue_full (queue_full)
   );

   mpd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .not_empty  (queue_not_empty),
      .pop_entry  (pop_entry)
   );

   mpd_back u_back (
      .clock           (clock),
      .reset           (reset),
      .queue_not_empty (queue_not_empty),
      .queue_entry     (pop_entry),
      .pop             (pop),
      .out_valid       (rsp_tvalid),
      .out_ready       (rsp_tready),
      .out_event       (out_event)
   );

   // pack the event beat
   assign rsp_tdata = {4'b0000, out_event.value, out_event.code};
   assign rsp_tuser = out_event.kind;
   assign rsp_tlast = out_event.last;

endmodule
